### rtl/fpa_pkg.sv
package fpa_pkg;

  localparam int FracBitsDef = 8;
  localparam int DataW = 32;
  localparam int ProdW = 64;
  localparam int QuoW = 64;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_GT   = 4'd4,
    OP_LT   = 4'd5,
    OP_GE   = 4'd6,
    OP_LE   = 4'd7,
    OP_EQ   = 4'd8,
    OP_NE   = 4'd9,
    OP_MIN  = 4'd10,
    OP_MAX  = 4'd11,
    OP_INC  = 4'd12,
    OP_DEC  = 4'd13,
    OP_FINT = 4'd14,
    OP_TINT = 4'd15
  } op_t;

  // Request that travels alongside the divider pipeline.
  typedef struct packed {
    op_t               op;
    logic [DataW-1:0]  res;
    logic              a_neg;
    logic              b_neg;
  } side_t;

endpackage

### rtl/fpa_div.sv
module fpa_div #(
  parameter int FRAC_BITS = fpa_pkg::FracBitsDef
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic [fpa_pkg::QuoW-1:0]    in_num,
  input  logic [fpa_pkg::DataW-1:0]   in_den,
  input  fpa_pkg::side_t              in_side,
  input  logic [fpa_pkg::ProdW-1:0]   in_prod,
  output logic                        out_vld,
  output logic [fpa_pkg::QuoW-1:0]    out_quo,
  output fpa_pkg::side_t              out_side,
  output logic [fpa_pkg::ProdW-1:0]   out_prod
);
  // Unsigned restoring divide, one quotient bit per stage; numerator magnitude
  // below 2^(31+FRAC_BITS)+1 so only the low NumW bits ever carry quotient.
  localparam int NumW = fpa_pkg::DataW + FRAC_BITS;
  localparam int RemW = fpa_pkg::DataW + 1;

  logic [NumW:0]               vld_r;
  logic [NumW:0][NumW-1:0]     num_r;
  logic [NumW:0][RemW-1:0]     rem_r;
  logic [NumW:0][fpa_pkg::DataW-1:0] den_r;
  fpa_pkg::side_t [NumW:0]     side_r;
  logic [NumW:0][fpa_pkg::ProdW-1:0] prod_r;

  always_comb begin
    vld_r[0]  = in_vld;
    num_r[0]  = in_num[NumW-1:0];
    rem_r[0]  = '0;
    den_r[0]  = in_den;
    side_r[0] = in_side;
    prod_r[0] = in_prod;
  end

  for (genvar s = 0; s < NumW; s++) begin : g_stage
    logic [RemW-1:0] sh;
    logic [RemW:0]   diff;
    assign sh   = {rem_r[s][RemW-2:0], num_r[s][NumW-1]};
    assign diff = {1'b0, sh} - {2'b0, den_r[s]};
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (en) begin
        vld_r[s+1] <= vld_r[s];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1]  <= diff[RemW] ? sh : diff[RemW-1:0];
        num_r[s+1]  <= {num_r[s][NumW-2:0], ~diff[RemW]};
        den_r[s+1]  <= den_r[s];
        side_r[s+1] <= side_r[s];
        prod_r[s+1] <= prod_r[s];
      end
    end
  end

  assign out_vld  = vld_r[NumW];
  assign out_quo  = {{(fpa_pkg::QuoW-NumW){1'b0}}, num_r[NumW]};
  assign out_side = side_r[NumW];
  assign out_prod = prod_r[NumW];
endmodule

### rtl/fixed_point_alu.sv
// Fixed-point ALU, signed Q(32-FRAC_BITS).FRAC_BITS (Q24.8 by default).
// One request per cycle in while the output is not stalled, one result per
// request out, in order. Every request, whatever its operation, runs through
// the same pipeline: a register stage for operands, a 32x32 multiply stage,
// a one-bit-per-stage restoring divider of 32+FRAC_BITS stages, and a
// sign/select stage feeding the output register. The whole pipeline advances
// when the output register is empty or taken, so a stall holds every stage in
// place. Divide by zero gives result 0 with error set.
module fixed_point_alu #(
  parameter int FRAC_BITS = fpa_pkg::FracBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // [3:0] func, [35:4] a, [67:36] b, zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [31:0] result, [32] error, zero fill
);
  localparam int DW = fpa_pkg::DataW;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // Stage 1: register operands.
  logic            s1_vld_r;
  fpa_pkg::op_t    s1_op_r;
  logic signed [DW-1:0] s1_a_r, s1_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_tvalid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1_op_r <= fpa_pkg::op_t'(in_tdata[3:0]);
      s1_a_r  <= in_tdata[35:4];
      s1_b_r  <= in_tdata[67:36];
    end
  end

  // Stage 2: simple operations, product, divider operand magnitudes.
  logic [DW-1:0] simple;
  logic          lt, eq;
  logic [DW-1:0] a_mag, b_mag;
  logic signed [fpa_pkg::ProdW-1:0] prod;
  fpa_pkg::side_t s2_side;

  assign lt    = s1_a_r < s1_b_r;
  assign eq    = s1_a_r == s1_b_r;
  assign a_mag = s1_a_r[DW-1] ? DW'(-s1_a_r) : DW'(s1_a_r);
  assign b_mag = s1_b_r[DW-1] ? DW'(-s1_b_r) : DW'(s1_b_r);
  assign prod  = s1_a_r * s1_b_r;

  always_comb begin
    case (s1_op_r)
      fpa_pkg::OP_ADD:  simple = s1_a_r + s1_b_r;
      fpa_pkg::OP_SUB:  simple = s1_a_r - s1_b_r;
      // Flag a zero divisor in bit 0 for the final stage.
      fpa_pkg::OP_DIV:  simple = DW'(s1_b_r == '0);
      fpa_pkg::OP_GT:   simple = DW'(!lt && !eq);
      fpa_pkg::OP_LT:   simple = DW'(lt);
      fpa_pkg::OP_GE:   simple = DW'(!lt);
      fpa_pkg::OP_LE:   simple = DW'(lt || eq);
      fpa_pkg::OP_EQ:   simple = DW'(eq);
      fpa_pkg::OP_NE:   simple = DW'(!eq);
      fpa_pkg::OP_MIN:  simple = lt ? s1_a_r : s1_b_r;
      fpa_pkg::OP_MAX:  simple = lt ? s1_b_r : s1_a_r;
      fpa_pkg::OP_INC:  simple = s1_a_r + DW'(1);
      fpa_pkg::OP_DEC:  simple = s1_a_r - DW'(1);
      fpa_pkg::OP_FINT: simple = s1_a_r << FRAC_BITS;
      fpa_pkg::OP_TINT: simple = s1_a_r >>> FRAC_BITS;
      default:          simple = '0;
    endcase
  end

  assign s2_side.op    = s1_op_r;
  assign s2_side.res   = simple;
  assign s2_side.a_neg = s1_a_r[DW-1];
  assign s2_side.b_neg = s1_b_r[DW-1];

  logic                               s2_vld_r;
  logic [fpa_pkg::QuoW-1:0]           s2_num_r;
  logic [DW-1:0]                      s2_den_r;
  fpa_pkg::side_t                     s2_side_r;
  logic [fpa_pkg::ProdW-1:0]          s2_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s2_num_r  <= {{(fpa_pkg::QuoW-DW){1'b0}}, a_mag} << FRAC_BITS;
      s2_den_r  <= b_mag;
      s2_side_r <= s2_side;
      s2_prod_r <= prod;
    end
  end

  // Divider stages; product and side data ride along.
  logic                      d_vld;
  logic [fpa_pkg::QuoW-1:0]  d_quo;
  fpa_pkg::side_t            d_side;
  logic [fpa_pkg::ProdW-1:0] d_prod;

  fpa_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s2_vld_r),
    .in_num   (s2_num_r),
    .in_den   (s2_den_r),
    .in_side  (s2_side_r),
    .in_prod  (s2_prod_r),
    .out_vld  (d_vld),
    .out_quo  (d_quo),
    .out_side (d_side),
    .out_prod (d_prod)
  );

  // Final stage: truncate product toward zero, sign the quotient, select.
  logic [fpa_pkg::ProdW-1:0] p_adj;
  logic [DW-1:0]             mul_res, div_res, res_nxt;
  logic                      err_nxt;

  assign p_adj   = d_prod + (d_prod[fpa_pkg::ProdW-1]
                   ? fpa_pkg::ProdW'((64'd1 << FRAC_BITS) - 64'd1) : '0);
  assign mul_res = DW'(p_adj >> FRAC_BITS);
  assign div_res = (d_side.a_neg ^ d_side.b_neg) ? DW'(-d_quo) : DW'(d_quo);

  always_comb begin
    err_nxt = 1'b0;
    case (d_side.op)
      fpa_pkg::OP_MUL: res_nxt = mul_res;
      fpa_pkg::OP_DIV: begin
        // Drop the quotient and raise error for a zero divisor.
        if (d_side.res[0]) begin
          res_nxt = '0;
          err_nxt = 1'b1;
        end else begin
          res_nxt = div_res;
        end
      end
      default: res_nxt = d_side.res;
    endcase
  end

  logic [DW-1:0] res_r;
  logic          err_r, ovld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (en) begin
      ovld_r <= d_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
      err_r <= err_nxt;
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = {7'b0, err_r, res_r};
endmodule

### tb/sv/fixed_point_alu_checker.sv
module fixed_point_alu_checker #(
  parameter int FRAC_BITS = fpa_pkg::FracBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [71:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] result;
    logic        error;
  } alu_result_t;

  alu_result_t expected_q[$];

  function automatic alu_result_t compute_alu(fpa_pkg::op_t op, logic signed [31:0] a,
                                              logic signed [31:0] b);
    alu_result_t r;
    logic signed [63:0] wa;
    logic signed [63:0] wb;
    logic signed [63:0] t;
    wa = a;
    wb = b;
    r.result = '0;
    r.error = 1'b0;
    case (op)
      fpa_pkg::OP_ADD: r.result = a + b;
      fpa_pkg::OP_SUB: r.result = a - b;
      fpa_pkg::OP_MUL: begin
        t = (wa * wb) / (64'sd1 <<< FRAC_BITS);
        r.result = t[31:0];
      end
      fpa_pkg::OP_DIV: begin
        if (b == 0) begin
          r.error = 1'b1;
        end else begin
          t = (wa <<< FRAC_BITS) / wb;
          r.result = t[31:0];
        end
      end
      fpa_pkg::OP_GT: r.result = {31'd0, a > b};
      fpa_pkg::OP_LT: r.result = {31'd0, a < b};
      fpa_pkg::OP_GE: r.result = {31'd0, a >= b};
      fpa_pkg::OP_LE: r.result = {31'd0, a <= b};
      fpa_pkg::OP_EQ: r.result = {31'd0, a == b};
      fpa_pkg::OP_NE: r.result = {31'd0, a != b};
      fpa_pkg::OP_MIN: r.result = (a < b) ? a : b;
      fpa_pkg::OP_MAX: r.result = (b > a) ? b : a;
      fpa_pkg::OP_INC: r.result = a + 1;
      fpa_pkg::OP_DEC: r.result = a - 1;
      fpa_pkg::OP_FINT: r.result = a << FRAC_BITS;
      default: r.result = a >>> FRAC_BITS;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    alu_result_t want;
    alu_result_t got;
    if (rst_n && in_tvalid && in_tready)
      expected_q.push_back(compute_alu(fpa_pkg::op_t'(in_tdata[3:0]), in_tdata[35:4],
                                       in_tdata[67:36]));
    if (rst_n && out_tvalid && out_tready) begin
      got.result = out_tdata[31:0];
      got.error = out_tdata[32];
      if (expected_q.size() == 0) begin
        fail_count <= fail_count + 1;
        if (fail_count < 10) $display("unexpected result %h err %b", got.result, got.error);
      end else begin
        want = expected_q.pop_front();
        if (want !== got || out_tdata[39:33] !== 7'd0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("mismatch: expected %h err %b, got %h err %b",
                     want.result, want.error, got.result, got.error);
        end
      end
    end
    pending <= expected_q.size();
  end

  initial fail_count = 0;
  initial pending = 0;
endmodule

### tb/sv/fixed_point_alu_tb.sv
module fixed_point_alu_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  int          fail_count;
  int          pending;
  bit          stim_done = 1'b0;

  always #6 clk = ~clk;

  fixed_point_alu u_top (.*);

  fixed_point_alu_checker u_chk (.*);

  // Draw a wait per request or result; a little over a third of draws hold no gap at all.
  function automatic int draw_gap();
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
  endfunction

  // Operand biased toward edge values so corners come up often.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'd0;
      3: return $urandom_range(0, 1) ? 32'hffff_ffff : 32'd1;
      4: return 32'($signed($urandom_range(0, 4096)) - 2048);
      default: return $urandom();
    endcase
  endfunction

  // Drop valid for the gap, present one request and hold it until accepted.
  task automatic send_request(fpa_pkg::op_t op, logic [31:0] a, logic [31:0] b);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, b, a, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Receiver: wait a random gap per result, then take it.
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  initial begin
    logic [31:0] ext[4];
    ext = '{32'h8000_0000, 32'h7fff_ffff, 32'd0, 32'hffff_ffff};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: every op once on extremes, plus the special cases.
    for (int i = 0; i < 16; i++)
      send_request(fpa_pkg::op_t'(i), ext[i % 4], ext[(i + 1) % 4]);
    send_request(fpa_pkg::OP_DIV, 32'h0000_0100, 32'd0);
    send_request(fpa_pkg::OP_DIV, 32'h8000_0000, 32'hffff_ffff);
    send_request(fpa_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000);
    send_request(fpa_pkg::OP_TINT, 32'hffff_ff01, 32'd0);
    send_request(fpa_pkg::OP_MUL, 32'hffff_ffff, 32'd1);
    send_request(fpa_pkg::OP_INC, 32'h7fff_ffff, 32'd0);
    send_request(fpa_pkg::OP_DEC, 32'h8000_0000, 32'd0);
    send_request(fpa_pkg::OP_FINT, 32'hffff_ffff, 32'd0);
    // Hold the sender until the pipeline has drained.
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    for (int n = 0; n < 1650; n++)
      send_request(fpa_pkg::op_t'($urandom_range(0, 15)), pick_operand(), pick_operand());
    in_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0)
      $display("fixed_point_alu_tb: PASS");
    else
      $display("fixed_point_alu_tb: FAIL");
    $finish;
  end

  // Worst case ~1700 requests, each with the longest sender and receiver gaps; allow several times that.
  initial begin
    #5ms;
    $display("fixed_point_alu_tb: FAIL");
    $finish;
  end
endmodule

### fixed_point_alu.f
rtl/fpa_pkg.sv
rtl/fpa_div.sv
rtl/fixed_point_alu.sv
tb/sv/fixed_point_alu_checker.sv
tb/sv/fixed_point_alu_tb.sv
